FILE: hdl/gcbrm_pkg.sv
`timescale 1ns / 1ps
// Shared constants and handshake structs for the gain, clip and band RMS meter.
package gcbrm_pkg;

    localparam int SAMPLE_W  = 16;
    localparam int GAIN_W    = 16;
    localparam int LEN_W     = 14;
    localparam int POS_W     = 13;
    localparam int BAND_W    = 5;
    localparam int RMS_W     = 15;
    localparam int SUM_W     = 44;
    localparam int REM_W     = 13;
    localparam int ROOT_W    = 31;   // subtractor and square-root working width
    localparam int STEP_W    = 6;
    localparam int CFG_IDX_W = 2;

    localparam int BAND_SHIFT = 5;   // 32 bands per frame
    localparam int GAIN_FRAC  = 14;

    localparam logic [GAIN_W-1:0] GAIN_MAX  = 16'd32768;
    localparam logic [LEN_W-1:0]  LEN_MIN   = 14'd32;
    localparam logic [LEN_W-1:0]  LEN_MAX   = 14'd8192;
    localparam logic [BAND_W-1:0] LAST_BAND = 5'd31;
    localparam logic [RMS_W-1:0]  RMS_MAX   = 15'd32767;

    localparam logic [STEP_W-1:0] DIV_STEPS  = 6'd43;  // one quotient bit per step
    localparam logic [STEP_W-1:0] ROOT_STEPS = 6'd15;  // one root bit per step

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PLAYING   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_LEN = 2'd2;

    typedef struct packed {
        logic             start;
        logic [SUM_W-1:0] dividend;
        logic [LEN_W-1:0] divisor;
    } root_req_t;

    typedef struct packed {
        logic             done;
        logic [RMS_W-1:0] root;
    } root_rsp_t;

endpackage

FILE: hdl/gcbrm_root_div.sv
`timescale 1ns / 1ps
// Iterative mean-square divider and integer square root on one shared subtractor.
module gcbrm_root_div
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  gcbrm_pkg::root_req_t  req,
    output gcbrm_pkg::root_rsp_t  rsp
);
    import gcbrm_pkg::*;

    typedef enum logic [3:0] {
        R_IDLE = 4'b0001,
        R_DIV  = 4'b0010,
        R_SQRT = 4'b0100,
        R_DONE = 4'b1000
    } rstate_t;

    rstate_t             state_reg, state_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    logic [SUM_W-1:0]    quo_reg, quo_next;
    logic [REM_W-1:0]    rem_reg, rem_next;
    logic [LEN_W-1:0]    dvs_reg, dvs_next;
    logic [ROOT_W-1:0]   v_reg, v_next;
    logic [ROOT_W-1:0]   res_reg, res_next;
    logic [ROOT_W-1:0]   bit_reg, bit_next;
    logic [RMS_W-1:0]    root_reg, root_next;

    // shared compare-subtract unit
    logic [ROOT_W-1:0]   op_a, op_b;
    logic [ROOT_W:0]     diff;
    logic                ge;
    logic [LEN_W-1:0]    trial;
    logic [ROOT_W-1:0]   res_step;

    assign trial = {rem_reg, quo_reg[SUM_W-1]};

    always_comb
    begin
        if (state_reg == R_SQRT)
        begin
            op_a = v_reg;
            op_b = res_reg | bit_reg;   // res and bit never overlap
        end
        else
        begin
            op_a = {{(ROOT_W-LEN_W){1'b0}}, trial};
            op_b = {{(ROOT_W-LEN_W){1'b0}}, dvs_reg};
        end
    end

    assign diff     = {1'b0, op_a} - {1'b0, op_b};
    assign ge       = ~diff[ROOT_W];
    assign res_step = ge ? ((res_reg >> 1) | bit_reg) : (res_reg >> 1);

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        quo_next   = quo_reg;
        rem_next   = rem_reg;
        dvs_next   = dvs_reg;
        v_next     = v_reg;
        res_next   = res_reg;
        bit_next   = bit_reg;
        root_next  = root_reg;
        case (state_reg)
            R_IDLE:
            begin
                if (req.start)
                begin
                    quo_next   = req.dividend;
                    dvs_next   = req.divisor;
                    rem_next   = '0;
                    step_next  = DIV_STEPS;
                    state_next = R_DIV;
                end
            end
            R_DIV:
            begin
                rem_next = ge ? diff[REM_W-1:0] : trial[REM_W-1:0];
                quo_next = {quo_reg[SUM_W-2:0], ge};
                if (step_reg == '0)
                begin
                    // quotient never exceeds a full-scale square
                    v_next     = quo_next[ROOT_W-1:0];
                    res_next   = '0;
                    bit_next   = {1'b1, {(ROOT_W-1){1'b0}}};
                    step_next  = ROOT_STEPS;
                    state_next = R_SQRT;
                end
                else
                begin
                    step_next = step_reg - 1'b1;
                end
            end
            R_SQRT:
            begin
                if (ge)
                begin
                    v_next = diff[ROOT_W-1:0];
                end
                res_next = res_step;
                bit_next = bit_reg >> 2;
                if (step_reg == '0)
                begin
                    // a band of full negative scale gives 32768: clip
                    root_next  = (res_step > {{(ROOT_W-RMS_W){1'b0}}, RMS_MAX})
                                 ? RMS_MAX : res_step[RMS_W-1:0];
                    state_next = R_DONE;
                end
                else
                begin
                    step_next = step_reg - 1'b1;
                end
            end
            R_DONE:
            begin
                state_next = R_IDLE;
            end
            default:
            begin
                state_next = R_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= R_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg  <= quo_next;
        rem_reg  <= rem_next;
        dvs_reg  <= dvs_next;
        v_reg    <= v_next;
        res_reg  <= res_next;
        bit_reg  <= bit_next;
        root_reg <= root_next;
    end

    assign rsp.done = (state_reg == R_DONE);
    assign rsp.root = root_reg;

endmodule

FILE: hdl/gain_clip_band_rms_meter.sv
`timescale 1ns / 1ps
// Top level: gain, saturation, band framing and RMS level metering.
// A playing beat passes through scale, saturate, square and accumulate to the output;
// one that closes a band also waits on the divider and square root on the shared subtractor.
// A stopped beat goes straight to the output. One beat in flight: the next is taken the
// cycle after the result is registered, and the output register may wait on out_stall.
// Reset (async, active low) restores playing=0, gain=unity x2, length=1024
// and clears frame position, band, sample count and sum of squares.
module gain_clip_band_rms_meter
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    // configuration write port
    input  logic                                 cfg_we,
    input  logic [gcbrm_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [gcbrm_pkg::GAIN_W-1:0]         cfg_data,
    // sample input
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic signed [gcbrm_pkg::SAMPLE_W-1:0] sample_in,
    // result output
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic signed [gcbrm_pkg::SAMPLE_W-1:0] sample_out,
    output logic                                 band_valid,
    output logic [gcbrm_pkg::BAND_W-1:0]         band_index,
    output logic [gcbrm_pkg::RMS_W-1:0]          band_rms,
    output logic                                 frame_last
);
    import gcbrm_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_SCALE  = 7'b0000010,
        S_SAT    = 7'b0000100,
        S_SQUARE = 7'b0001000,
        S_ACC    = 7'b0010000,
        S_ROOT   = 7'b0100000,
        S_OUT    = 7'b1000000
    } state_t;

    state_t state_reg;

    // configuration
    logic                 playing_reg;
    logic [GAIN_W-1:0]    gain_reg;
    logic [LEN_W-1:0]     frame_len_reg;

    // metering state
    logic [POS_W-1:0]     pos_reg;
    logic [BAND_W-1:0]    band_reg;
    logic [POS_W-1:0]     count_reg;
    logic [SUM_W-1:0]     sum_reg;

    // per-beat working registers
    logic signed [SAMPLE_W-1:0] sample_reg;
    logic signed [31:0]         prod_reg;
    logic signed [SAMPLE_W-1:0] y_reg;
    logic                       bvalid_reg;
    logic [BAND_W-1:0]          bindex_reg;
    logic [RMS_W-1:0]           rms_reg;
    logic                       last_reg;

    // output register
    logic                       ovalid_reg;
    logic signed [SAMPLE_W-1:0] osample_reg;
    logic                       obvalid_reg;
    logic [BAND_W-1:0]          obindex_reg;
    logic [RMS_W-1:0]           orms_reg;
    logic                       olast_reg;

    root_req_t root_req;
    root_rsp_t root_rsp;

    // --- shared 17x17 signed multiplier: gain in SCALE, square in SQUARE ---
    logic [GAIN_W-1:0]   gain_eff;
    logic signed [16:0]  mul_a, mul_b;
    logic signed [33:0]  mul_p;

    assign gain_eff = (gain_reg > GAIN_MAX) ? GAIN_MAX : gain_reg;

    always_comb
    begin
        if (state_reg == S_SCALE)
        begin
            mul_a = {sample_reg[SAMPLE_W-1], sample_reg};
            mul_b = $signed({1'b0, gain_eff});
        end
        else
        begin
            mul_a = {y_reg[SAMPLE_W-1], y_reg};
            mul_b = {y_reg[SAMPLE_W-1], y_reg};
        end
    end

    assign mul_p = mul_a * mul_b;

    // --- round Q3.29 to Q1.15 (add half, floor) and saturate ---
    logic signed [31:0] rnd;
    logic signed [17:0] scaled;
    logic signed [SAMPLE_W-1:0] y_sat;

    assign rnd    = prod_reg + 32'sd8192;
    assign scaled = rnd[31:GAIN_FRAC];

    always_comb
    begin
        if (scaled > 18'sd32767)
        begin
            y_sat = 16'sh7FFF;
        end
        else if (scaled < -18'sd32768)
        begin
            y_sat = 16'sh8000;
        end
        else
        begin
            y_sat = scaled[SAMPLE_W-1:0];
        end
    end

    // --- band and frame boundaries ---
    logic [LEN_W-1:0] len_eff;
    logic [LEN_W-1:0] per_band;
    logic [LEN_W-1:0] pos_inc;
    logic [LEN_W-1:0] count_inc;
    logic [SUM_W-1:0] sum_new;
    logic             frame_end;
    logic             band_end;

    always_comb
    begin
        if (frame_len_reg < LEN_MIN)
        begin
            len_eff = LEN_MIN;
        end
        else if (frame_len_reg > LEN_MAX)
        begin
            len_eff = LEN_MAX;
        end
        else
        begin
            len_eff = frame_len_reg;
        end
    end

    assign per_band  = len_eff >> BAND_SHIFT;
    assign pos_inc   = {1'b0, pos_reg} + 1'b1;
    assign count_inc = {1'b0, count_reg} + 1'b1;
    assign sum_new   = sum_reg + {{(SUM_W-31){1'b0}}, prod_reg[30:0]};
    assign frame_end = (pos_inc >= len_eff);
    // the last band only closes with the frame, so it soaks up the remainder
    assign band_end  = frame_end ||
                       ((band_reg < LAST_BAND) && (count_inc >= per_band));

    assign root_req.start    = (state_reg == S_ACC) && band_end;
    assign root_req.dividend = sum_new;
    assign root_req.divisor  = count_inc;

    gcbrm_root_div u_root_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (root_req),
        .rsp   (root_rsp)
    );

    // --- configuration registers ---
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            playing_reg   <= 1'b0;
            gain_reg      <= GAIN_MAX;
            frame_len_reg <= 14'd1024;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_PLAYING:   playing_reg   <= cfg_data[0];
                REG_GAIN:      gain_reg      <= cfg_data;
                REG_FRAME_LEN: frame_len_reg <= cfg_data[LEN_W-1:0];
                default:       ;
            endcase
        end
    end

    // --- sequencer and metering state ---
    logic out_free;
    assign out_free = !ovalid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            pos_reg    <= '0;
            band_reg   <= '0;
            count_reg  <= '0;
            sum_reg    <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            // a new beat may load the output register as the old one leaves
            if ((state_reg == S_OUT) && out_free)
            begin
                ovalid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                ovalid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        // silence skips the datapath and leaves metering untouched
                        state_reg <= playing_reg ? S_SCALE : S_OUT;
                    end
                end
                S_SCALE:  state_reg <= S_SAT;
                S_SAT:    state_reg <= S_SQUARE;
                S_SQUARE: state_reg <= S_ACC;
                S_ACC:
                begin
                    if (band_end)
                    begin
                        sum_reg   <= '0;
                        count_reg <= '0;
                        // frame end restarts at the first band
                        band_reg  <= frame_end ? '0 : band_reg + 1'b1;
                    end
                    else
                    begin
                        sum_reg   <= sum_new;
                        count_reg <= count_inc[POS_W-1:0];
                    end
                    if (frame_end)
                    begin
                        pos_reg <= '0;
                    end
                    else
                    begin
                        pos_reg <= pos_inc[POS_W-1:0];
                    end
                    state_reg <= band_end ? S_ROOT : S_OUT;
                end
                S_ROOT:
                begin
                    if (root_rsp.done)
                    begin
                        state_reg <= S_OUT;
                    end
                end
                S_OUT:
                begin
                    if (out_free)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // --- datapath registers ---
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                sample_reg <= sample_in;
                y_reg      <= '0;
                bvalid_reg <= 1'b0;
                bindex_reg <= '0;
                rms_reg    <= '0;
                last_reg   <= 1'b0;
            end
            S_SCALE:  prod_reg <= mul_p[31:0];
            S_SAT:    y_reg    <= y_sat;
            S_SQUARE: prod_reg <= mul_p[31:0];
            S_ACC:
            begin
                bvalid_reg <= band_end;
                bindex_reg <= band_end ? band_reg : '0;
                last_reg   <= frame_end;
            end
            S_ROOT:
            begin
                if (root_rsp.done)
                begin
                    rms_reg <= root_rsp.root;
                end
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    osample_reg <= y_reg;
                    obvalid_reg <= bvalid_reg;
                    obindex_reg <= bindex_reg;
                    orms_reg    <= rms_reg;
                    olast_reg   <= last_reg;
                end
            end
            default: ;
        endcase
    end

    assign in_stall   = (state_reg != S_IDLE);
    assign out_valid  = ovalid_reg;
    assign sample_out = osample_reg;
    assign band_valid = obvalid_reg;
    assign band_index = obindex_reg;
    assign band_rms   = orms_reg;
    assign frame_last = olast_reg;

endmodule
